/* hw/rtl/dptc_pkg.sv */
// ----------------------------------------------------------------------------
// dptc_pkg
// Shared constants, types and codes for the decimal print text console.
// ----------------------------------------------------------------------------
package dptc_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;

    localparam int VALUE_W    = 32;
    localparam int DIGITS     = 10;
    localparam int BCD_W      = DIGITS * 4;
    localparam int OFF_W      = 12;
    localparam int CHAR_W     = 6;
    localparam int COLOR_W    = 4;
    localparam int ATTR_W     = 2 * COLOR_W;
    localparam int COL_W      = $clog2(COLUMNS + 1);
    localparam int ROW_W      = $clog2(ROWS + 1);
    localparam int LEFT_W     = $clog2(DIGITS + 1);
    localparam int BIT_CNT_W  = $clog2(VALUE_W + 1);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FOREGROUND = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_BACKGROUND = t_cfg_idx'(1);

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd2;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic start;
        logic negative;
    } t_emit_ctl;

    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] digits;
    } t_bcd_res;

endpackage

/* hw/rtl/dptc_if.sv */
// ----------------------------------------------------------------------------
// dptc_if
// Valid/ready channels: input value, character cell writes, register writes.
// ----------------------------------------------------------------------------
interface dptc_in_if;
    import dptc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface dptc_out_if;
    import dptc_pkg::*;
    logic              valid;
    logic              ready;
    logic [OFF_W-1:0]  cell_offset;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic              last_char;

    modport source (output valid, output cell_offset, output char_code,
                    output attribute, output last_char, input ready);
    modport sink   (input valid, input cell_offset, input char_code,
                    input attribute, input last_char, output ready);
endinterface

interface dptc_cfg_if;
    import dptc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/decimal_print_text_console.sv */
// ----------------------------------------------------------------------------
// decimal_print_text_console
// Prints a signed 32-bit value as decimal text into an 80x25 text cell grid.
// ----------------------------------------------------------------------------
// One value is taken at a time and gives one cell write per character: an
// optional minus sign, then the digits most significant first, the final
// write flagged by last_char. From acceptance a value passes through the
// bit-serial shift-and-add-3 converter, then the digits are taken, leading
// zeros are dropped, the zero skip is left and each character is written.
// The next value is taken as soon as the final write of the previous one
// sits in the output register. The cursor wraps columns into rows and the
// last row to the top.
// Colour registers: index 0 foreground, index 1 background, low four bits
// of the data kept; writes are always taken.
module decimal_print_text_console (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dptc_in_if.sink     i_item,
    dptc_cfg_if.sink    i_cfg,
    dptc_out_if.source  o_res
);
    import dptc_pkg::*;

    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    logic               idle;
    logic               accept;
    logic [VALUE_W-1:0] mag;
    t_emit_ctl          ctl;
    t_bcd_res           bcd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FOREGROUND: r_fg <= i_cfg.data[COLOR_W-1:0];
                CFG_BACKGROUND: r_bg <= i_cfg.data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_item.ready = idle;
    assign accept       = i_item.valid && idle;
    assign mag          = i_item.value[VALUE_W-1] ? VALUE_W'(0) - VALUE_W'(i_item.value)
                                                  : VALUE_W'(i_item.value);
    assign ctl.start    = accept;
    assign ctl.negative = i_item.value[VALUE_W-1];

    dptc_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_mag   (mag),
        .o_res   (bcd)
    );

    dptc_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_bcd   (bcd),
        .i_attr  ({r_bg, r_fg}),
        .o_idle  (idle),
        .o_res   (o_res)
    );

endmodule

/* hw/rtl/dptc_bcd.sv */
// ----------------------------------------------------------------------------
// dptc_bcd
// Bit-serial binary to BCD converter, shift and add-3, one bit per cycle.
// ----------------------------------------------------------------------------
module dptc_bcd (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dptc_pkg::VALUE_W-1:0]   i_mag,
    output dptc_pkg::t_bcd_res             o_res
);
    import dptc_pkg::*;

    logic [VALUE_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [BCD_W-1:0]     adj;
    logic [BIT_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                       : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_mag;
            n_bcd  = '0;
            n_cnt  = BIT_CNT_W'(VALUE_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt - BIT_CNT_W'(1);
            if (r_cnt == BIT_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_res.done   = r_done;
    assign o_res.digits = r_bcd;

endmodule

/* hw/rtl/dptc_emit.sv */
// ----------------------------------------------------------------------------
// dptc_emit
// Character sequencer: drops leading zeros, writes sign and digits, keeps
// the cursor and the output register.
// ----------------------------------------------------------------------------
module dptc_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dptc_pkg::t_emit_ctl           i_ctl,
    input  dptc_pkg::t_bcd_res            i_bcd,
    input  logic [dptc_pkg::ATTR_W-1:0]   i_attr,
    output logic                          o_idle,
    dptc_out_if.source                    o_res
);
    import dptc_pkg::*;

    t_state            r_state, n_state;
    logic              r_neg;
    logic [BCD_W-1:0]  r_digits;
    logic [LEFT_W-1:0] r_left;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [OFF_W-1:0]  r_off;

    logic              r_valid;
    logic [OFF_W-1:0]  r_out_off;
    logic [CHAR_W-1:0] r_out_char;
    logic [ATTR_W-1:0] r_out_attr;
    logic              r_out_last;

    logic              slot_free;
    logic              skip;
    logic              load;
    logic              shift;
    logic [CHAR_W-1:0] load_char;
    logic              load_last;

    assign slot_free = !r_valid || o_res.ready;
    assign skip      = (r_digits[BCD_W-1 -: 4] == 4'd0) && (r_left != LEFT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_ctl.start) n_state = S_CONV;
            S_CONV:  if (i_bcd.done) n_state = S_SKIP;
            S_SKIP:  if (!skip) n_state = r_neg ? S_SIGN : S_DIGIT;
            S_SIGN:  if (slot_free) n_state = S_DIGIT;
            S_DIGIT: if (slot_free && r_left == LEFT_W'(1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        load      = 1'b0;
        shift     = 1'b0;
        load_char = CHAR_ZERO + CHAR_W'(r_digits[BCD_W-1 -: 4]);
        load_last = 1'b0;
        unique case (r_state)
            S_SKIP:  shift = skip;
            S_SIGN: begin
                load      = slot_free;
                load_char = CHAR_MINUS;
            end
            S_DIGIT: begin
                load      = slot_free;
                shift     = slot_free;
                load_last = (r_left == LEFT_W'(1));
            end
            default: ;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_off   <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
            if (r_state == S_CONV && i_bcd.done) begin
                r_left <= LEFT_W'(DIGITS);
            end else if (shift) begin
                r_left <= r_left - LEFT_W'(1);
            end
            if (load) begin
                if (r_col == COL_W'(COLUMNS - 1)) begin
                    r_col <= '0;
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        r_row <= '0;
                        r_off <= '0;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                        r_off <= r_off + OFF_W'(2);
                    end
                end else begin
                    r_col <= r_col + COL_W'(1);
                    r_off <= r_off + OFF_W'(2);
                end
            end
        end
        if (r_state == S_IDLE && i_ctl.start) begin
            r_neg <= i_ctl.negative;
        end
        if (r_state == S_CONV && i_bcd.done) begin
            r_digits <= i_bcd.digits;
        end else if (shift) begin
            r_digits <= {r_digits[BCD_W-5:0], 4'd0};
        end
        if (load) begin
            r_out_off  <= r_off;
            r_out_char <= load_char;
            r_out_attr <= i_attr;
            r_out_last <= load_last;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.cell_offset = r_out_off;
    assign o_res.char_code   = r_out_char;
    assign o_res.attribute   = r_out_attr;
    assign o_res.last_char   = r_out_last;

`ifndef NO_ASSERTIONS
    a_offset_tracks_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off == OFF_W'((int'(r_row) * COLUMNS + int'(r_col)) * 2))
        else $error("cell offset out of step with cursor");

    a_cursor_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_col) < COLUMNS) && (int'(r_row) < ROWS))
        else $error("cursor outside grid");

    a_digit_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT || r_state == S_SIGN) |-> (r_left != '0))
        else $error("no digit left while writing");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && load_last) |=> (r_state == S_IDLE) && o_res.last_char)
        else $error("final character did not end the item");
`endif

endmodule
